@@ hw/rtl/soft_ellipsoid_brush_voxel_unit_macros.svh @@
// Assertion macros shared by the soft ellipsoid brush voxel unit.
`ifndef SOFT_ELLIPSOID_BRUSH_VOXEL_UNIT_MACROS_SVH
`define SOFT_ELLIPSOID_BRUSH_VOXEL_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define SEBV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define SEBV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SEBV_ASSERT(lbl, prop, msg)
`define SEBV_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ hw/rtl/sebv_pkg.sv @@
// Types, widths and constants of the soft ellipsoid brush voxel unit.
package sebv_pkg;

  localparam int IDX_W   = 10;  // voxel index bits
  localparam int FRAC_W  = 16;  // fraction bits of coordinates
  localparam int SCALE_W = 24;
  localparam int OFF_W   = 32;
  localparam int TRANS_W = 16;
  localparam int VAL_W   = 8;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  localparam int PROD_W = IDX_W + SCALE_W;
  localparam int C_W    = ((PROD_W + 1 > OFF_W) ? PROD_W + 1 : OFF_W) + 1;
  localparam int MAG_W  = FRAC_W + 2;       // |c| saturated at 2.0
  localparam int SQ_W   = 2 * FRAC_W + 3;
  localparam int SUM_W  = 2 * FRAC_W + 4;
  localparam int RAD_W  = 2 * FRAC_W + 2;   // band sums stay below (2.0)^2
  localparam int RADX_W = RAD_W + 1;
  localparam int ROOT_W = FRAC_W + 1;
  localparam int N_W    = FRAC_W + 3;
  localparam int N255_W = N_W + 8;
  localparam int NUM_W  = FRAC_W + 9;
  localparam int QUOT_W = 8;

  localparam int SQRT_STEPS  = 2;
  localparam int SQRT_STAGES = (ROOT_W + SQRT_STEPS - 1) / SQRT_STEPS;
  localparam int DIV_STEPS   = 2;
  localparam int DIV_STAGES  = (QUOT_W + DIV_STEPS - 1) / DIV_STEPS;

  localparam logic [FRAC_W:0]    ONE     = (FRAC_W + 1)'(1) << FRAC_W;
  localparam logic [C_W-1:0]     SAT_MAG = C_W'(2) << FRAC_W;
  localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(1) << FRAC_W;
  localparam logic [TRANS_W-1:0] TRANS_RST = TRANS_W'(13107);

  localparam logic [VAL_W-1:0] VAL_OUT = VAL_W'(0);
  localparam logic [VAL_W-1:0] VAL_MIN = VAL_W'(1);
  localparam logic [VAL_W-1:0] VAL_MAX = VAL_W'(254);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE_X    = 3'd0,
    REG_SCALE_Y    = 3'd1,
    REG_SCALE_Z    = 3'd2,
    REG_OFFSET_X   = 3'd3,
    REG_OFFSET_Y   = 3'd4,
    REG_OFFSET_Z   = 3'd5,
    REG_TRANSITION = 3'd6,
    REG_POLARITY   = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    CLS_OUT  = 2'd0,
    CLS_CORE = 2'd1,
    CLS_BAND = 2'd2
  } cls_e;

  typedef struct packed {
    logic valid;
    cls_e cls;
  } stage_tag_t;

  // band width t moved from Q0.16 to FRAC_W fraction bits
  function automatic logic [FRAC_W-1:0] tf_of(input logic [TRANS_W-1:0] t);
    logic [TRANS_W+FRAC_W-1:0] w;
    w = {t, {FRAC_W{1'b0}}} >> TRANS_W;
    return w[FRAC_W-1:0];
  endfunction

endpackage

@@ hw/rtl/sebv_in_if.sv @@
// Voxel request channel: valid/ready with the three voxel indices.
interface sebv_in_if import sebv_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] voxel_x;
  logic [IDX_W-1:0] voxel_y;
  logic [IDX_W-1:0] voxel_z;

  modport source (output valid, output voxel_x, output voxel_y, output voxel_z,
                  input ready);
  modport sink (input valid, input voxel_x, input voxel_y, input voxel_z,
                output ready);
endinterface

@@ hw/rtl/sebv_out_if.sv @@
// Brush value result channel: valid/ready with the 8-bit value.
interface sebv_out_if import sebv_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] brush_value;

  modport source (output valid, output brush_value, input ready);
  modport sink (input valid, input brush_value, output ready);
endinterface

@@ hw/rtl/sebv_axis.sv @@
// One axis: index times scale, plus offset, magnitude saturation, square.
module sebv_axis import sebv_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [IDX_W-1:0]        idx_i,
  input  logic [SCALE_W-1:0]      scale_i,
  input  logic signed [OFF_W-1:0] offset_i,
  output logic [SQ_W-1:0]         sq_o
);

  logic [PROD_W-1:0]   prod_q;
  logic [MAG_W-1:0]    mag_q;
  logic [SQ_W-1:0]     sq_q;
  logic signed [C_W-1:0] coord;
  logic [C_W-1:0]      mag_full;
  logic [SQ_W-1:0]     mag_ext;

  always_comb begin
    coord    = $signed({{(C_W - PROD_W){1'b0}}, prod_q}) + C_W'(offset_i);
    mag_full = coord[C_W-1] ? C_W'(-coord) : C_W'(coord);
    if (mag_full > SAT_MAG) begin
      mag_full = SAT_MAG;
    end
    mag_ext = SQ_W'(mag_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PROD_W'(idx_i) * PROD_W'(scale_i);
      mag_q  <= mag_full[MAG_W-1:0];
      sq_q   <= mag_ext * mag_ext;
    end
  end

  assign sq_o = sq_q;

endmodule

@@ hw/rtl/sebv_isqrt.sv @@
// Pipelined digit-by-digit integer square root, SQRT_STEPS root bits a stage.
module sebv_isqrt import sebv_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  stage_tag_t        tag_i,
  input  logic [RAD_W-1:0]  rad_i,
  output stage_tag_t        tag_o,
  output logic [ROOT_W-1:0] root_o
);

  stage_tag_t        tag_q  [SQRT_STAGES];
  logic [RAD_W-1:0]  rem_q  [SQRT_STAGES];
  logic [ROOT_W-1:0] root_q [SQRT_STAGES];

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
    stage_tag_t        tag_in;
    logic [RAD_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [RAD_W-1:0]  rem_nx;
    logic [ROOT_W-1:0] root_nx;

    if (s == 0) begin : g_first
      assign tag_in  = tag_i;
      assign rem_in  = rad_i;
      assign root_in = '0;
    end else begin : g_next
      assign tag_in  = tag_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
    end

    // rem holds rad - root^2; adding 2^bi to root costs root*2^(bi+1) + 4^bi
    always_comb begin
      int bi;
      logic [RADX_W-1:0] inc;
      rem_nx  = rem_in;
      root_nx = root_in;
      for (int j = 0; j < SQRT_STEPS; j++) begin
        bi  = ROOT_W - 1 - (s * SQRT_STEPS + j);
        inc = '0;
        if (bi >= 0) begin
          inc = (RADX_W'(root_nx) << (bi + 1)) + (RADX_W'(1) << (2 * bi));
          if (RADX_W'(rem_nx) >= inc) begin
            rem_nx  = rem_nx - inc[RAD_W-1:0];
            root_nx = root_nx | (ROOT_W'(1) << bi);
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[s] <= '{valid: 1'b0, cls: CLS_OUT};
      end else if (en_i) begin
        tag_q[s] <= tag_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_nx;
        root_q[s] <= root_nx;
      end
    end
  end

  assign tag_o  = tag_q[SQRT_STAGES-1];
  assign root_o = root_q[SQRT_STAGES-1];

endmodule

@@ hw/rtl/sebv_band.sv @@
// Falloff band: numerator setup, pipelined 8-bit quotient, final value select.
module sebv_band import sebv_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  stage_tag_t         tag_i,
  input  logic [ROOT_W-1:0]  root_i,
  input  logic [TRANS_W-1:0] transition_i,
  input  logic               draw_i,
  output logic               valid_o,
  output logic [VAL_W-1:0]   value_o
);

  logic [FRAC_W-1:0] tf;
  logic [NUM_W-1:0]  den;

  // setup stage
  stage_tag_t        tag0_q;
  logic              low0_q;
  logic              sat0_q;
  logic [NUM_W-1:0]  num0_q;

  logic signed [N_W-1:0]    dist_e;
  logic signed [N_W-1:0]    n_val;
  logic signed [N_W-1:0]    den_s;
  logic signed [N255_W-1:0] n255;

  // divider stages
  stage_tag_t        tag_q [DIV_STAGES];
  logic              low_q [DIV_STAGES];
  logic              sat_q [DIV_STAGES];
  logic [NUM_W-1:0]  rem_q [DIV_STAGES];
  logic [QUOT_W-1:0] quo_q [DIV_STAGES];

  assign tf  = tf_of(transition_i);
  assign den = NUM_W'({tf, 1'b0});

  // value = floor(255*n / 2tf) with n = tf +/- (1 - d)
  always_comb begin
    dist_e = $signed(N_W'(ONE)) - $signed(N_W'(root_i));
    n_val  = draw_i ? ($signed(N_W'(tf)) + dist_e) : ($signed(N_W'(tf)) - dist_e);
    den_s  = $signed(N_W'({tf, 1'b0}));
    n255   = (N255_W'(n_val) <<< 8) - N255_W'(n_val);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag0_q <= '{valid: 1'b0, cls: CLS_OUT};
    end else if (en_i) begin
      tag0_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      low0_q <= n255 < N255_W'(den_s);
      sat0_q <= n_val >= den_s;
      num0_q <= n255[NUM_W-1:0];
    end
  end

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    stage_tag_t        tag_in;
    logic              low_in;
    logic              sat_in;
    logic [NUM_W-1:0]  rem_in;
    logic [QUOT_W-1:0] quo_in;
    logic [NUM_W-1:0]  rem_nx;
    logic [QUOT_W-1:0] quo_nx;

    if (s == 0) begin : g_first
      assign tag_in = tag0_q;
      assign low_in = low0_q;
      assign sat_in = sat0_q;
      assign rem_in = num0_q;
      assign quo_in = '0;
    end else begin : g_next
      assign tag_in = tag_q[s-1];
      assign low_in = low_q[s-1];
      assign sat_in = sat_q[s-1];
      assign rem_in = rem_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    always_comb begin
      int b;
      logic [NUM_W-1:0] dsh;
      rem_nx = rem_in;
      quo_nx = quo_in;
      for (int j = 0; j < DIV_STEPS; j++) begin
        b   = QUOT_W - 1 - (s * DIV_STEPS + j);
        dsh = '0;
        if (b >= 0) begin
          dsh = den << b;
          if (rem_nx >= dsh) begin
            rem_nx = rem_nx - dsh;
            quo_nx = quo_nx | (QUOT_W'(1) << b);
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[s] <= '{valid: 1'b0, cls: CLS_OUT};
      end else if (en_i) begin
        tag_q[s] <= tag_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        low_q[s] <= low_in;
        sat_q[s] <= sat_in;
        rem_q[s] <= rem_nx;
        quo_q[s] <= quo_nx;
      end
    end
  end

  always_comb begin
    case (tag_q[DIV_STAGES-1].cls)
      CLS_OUT:  value_o = VAL_OUT;
      CLS_CORE: value_o = draw_i ? VAL_MAX : VAL_MIN;
      CLS_BAND: begin
        if (low_q[DIV_STAGES-1]) begin
          value_o = VAL_MIN;
        end else if (sat_q[DIV_STAGES-1]) begin
          value_o = VAL_MAX;
        end else begin
          value_o = VAL_W'(quo_q[DIV_STAGES-1]);
        end
      end
      default:  value_o = VAL_OUT;
    endcase
  end

  assign valid_o = tag_q[DIV_STAGES-1].valid;

endmodule

@@ hw/rtl/soft_ellipsoid_brush_voxel_unit.sv @@
// Soft ellipsoid brush voxel unit: top level, config registers, sum and skid.
//
//   channel   dir  handshake         payload
//   req       in   valid/ready       voxel_x, voxel_y, voxel_z
//   rsp       out  valid/ready       brush_value
//   cfg       in   cfg_we_i          cfg_idx_i, cfg_wdata_i
//
// One voxel enters per cycle while the skid register is empty; its value passes 3 axis
// stages, the sum/compare stage, 9 square root stages and 5 band stages (set by the
// two root bits and two quotient bits resolved per stage).
// Reset clears all valid bits and loads the default brush registers.
// A stalled result moves into a one-entry skid register; while it is full the
// whole pipeline holds and req.ready is low.
`include "soft_ellipsoid_brush_voxel_unit_macros.svh"

module soft_ellipsoid_brush_voxel_unit import sebv_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  sebv_in_if.sink               req,
  sebv_out_if.source            rsp
);

  logic [SCALE_W-1:0]      scale_x_q, scale_y_q, scale_z_q;
  logic signed [OFF_W-1:0] offset_x_q, offset_y_q, offset_z_q;
  logic [TRANS_W-1:0]      transition_q;
  logic                    draw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_x_q    <= SCALE_RST;
      scale_y_q    <= SCALE_RST;
      scale_z_q    <= SCALE_RST;
      offset_x_q   <= '0;
      offset_y_q   <= '0;
      offset_z_q   <= '0;
      transition_q <= TRANS_RST;
      draw_q       <= 1'b1;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_SCALE_X:    scale_x_q    <= cfg_wdata_i[SCALE_W-1:0];
        REG_SCALE_Y:    scale_y_q    <= cfg_wdata_i[SCALE_W-1:0];
        REG_SCALE_Z:    scale_z_q    <= cfg_wdata_i[SCALE_W-1:0];
        REG_OFFSET_X:   offset_x_q   <= $signed(cfg_wdata_i[OFF_W-1:0]);
        REG_OFFSET_Y:   offset_y_q   <= $signed(cfg_wdata_i[OFF_W-1:0]);
        REG_OFFSET_Z:   offset_z_q   <= $signed(cfg_wdata_i[OFF_W-1:0]);
        REG_TRANSITION: transition_q <= cfg_wdata_i[TRANS_W-1:0];
        REG_POLARITY:   draw_q       <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic skid_v_q;
  logic [VAL_W-1:0] skid_val_q;

  assign adv       = !skid_v_q;
  assign req.ready = adv;

  // front valid bits ride alongside the axis stages
  logic [2:0] fv_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= '0;
    end else if (adv) begin
      fv_q <= {fv_q[1:0], req.valid};
    end
  end

  logic [SQ_W-1:0] sq_x, sq_y, sq_z;

  sebv_axis u_axis_x (
    .clk_i   (clk_i),
    .en_i    (adv),
    .idx_i   (req.voxel_x),
    .scale_i (scale_x_q),
    .offset_i(offset_x_q),
    .sq_o    (sq_x)
  );

  sebv_axis u_axis_y (
    .clk_i   (clk_i),
    .en_i    (adv),
    .idx_i   (req.voxel_y),
    .scale_i (scale_y_q),
    .offset_i(offset_y_q),
    .sq_o    (sq_y)
  );

  sebv_axis u_axis_z (
    .clk_i   (clk_i),
    .en_i    (adv),
    .idx_i   (req.voxel_z),
    .scale_i (scale_z_q),
    .offset_i(offset_z_q),
    .sq_o    (sq_z)
  );

  // band thresholds (1+t)^2 and (1-t)^2; registers must only change while idle, which the block does not enforce
  logic [FRAC_W-1:0] tf;
  logic [FRAC_W:0]   opl_ext, omi_ext;
  logic [RAD_W-1:0]  hi_q, lo_q;

  assign tf      = tf_of(transition_q);
  assign opl_ext = ONE + (FRAC_W + 1)'(tf);
  assign omi_ext = ONE - (FRAC_W + 1)'(tf);

  always_ff @(posedge clk_i) begin
    hi_q <= RAD_W'(opl_ext) * RAD_W'(opl_ext);
    lo_q <= RAD_W'(omi_ext) * RAD_W'(omi_ext);
  end

  logic [SUM_W-1:0] sum;
  cls_e             cls;
  stage_tag_t       sum_tag_q;
  logic [RAD_W-1:0] sum_q;

  always_comb begin
    sum = SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);
    if (sum > SUM_W'(hi_q)) begin
      cls = CLS_OUT;
    end else if (sum <= SUM_W'(lo_q)) begin
      cls = CLS_CORE;
    end else begin
      cls = CLS_BAND;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_tag_q <= '{valid: 1'b0, cls: CLS_OUT};
    end else if (adv) begin
      sum_tag_q <= '{valid: fv_q[2], cls: cls};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sum_q <= sum[RAD_W-1:0];
    end
  end

  stage_tag_t        root_tag;
  logic [ROOT_W-1:0] root;

  sebv_isqrt u_isqrt (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (adv),
    .tag_i (sum_tag_q),
    .rad_i (sum_q),
    .tag_o (root_tag),
    .root_o(root)
  );

  logic             band_v;
  logic [VAL_W-1:0] band_val;

  sebv_band u_band (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (adv),
    .tag_i       (root_tag),
    .root_i      (root),
    .transition_i(transition_q),
    .draw_i      (draw_q),
    .valid_o     (band_v),
    .value_o     (band_val)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      skid_v_q <= !rsp.ready;
    end else begin
      skid_v_q <= band_v && !rsp.ready;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && band_v && !rsp.ready) begin
      skid_val_q <= band_val;
    end
  end

  assign rsp.valid       = skid_v_q || band_v;
  assign rsp.brush_value = skid_v_q ? skid_val_q : band_val;

  `SEBV_ASSERT(a_value_range, rsp.valid |-> (rsp.brush_value <= VAL_MAX), "brush value above 254")
  `SEBV_ASSERT_NEXT(a_skid_hold, skid_v_q && !rsp.ready, skid_v_q && $stable(skid_val_q), "skid lost a waiting result")
  `SEBV_ASSERT_NEXT(a_skid_drain, skid_v_q && rsp.ready, !skid_v_q, "skid kept a delivered result")
  `SEBV_ASSERT(a_skid_fill, $rose(skid_v_q) |-> $past(band_v && !rsp.ready), "skid filled without a stalled result")
  `SEBV_ASSERT_NEXT(a_pipe_frozen, skid_v_q, $stable(band_val) && $stable(band_v), "pipeline moved while skid full")

endmodule
